// ===== sv/session_timeout_table_defines.svh =====
// ---------------------------------------------------------------------------
// Session timeout table: assertion macros
// Shared property wrappers for the checker of the session table.
// ---------------------------------------------------------------------------
`ifndef SESSION_TIMEOUT_TABLE_DEFINES_SVH
`define SESSION_TIMEOUT_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst is high
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst is high
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stt_pkg.sv =====
// ---------------------------------------------------------------------------
// Session timeout table: package
// Opcodes, status codes, controller states, beat payload types and the timeout reset value.
// ---------------------------------------------------------------------------
package stt_pkg;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_QUERY   = 2'd1,
    OP_REFRESH = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ACT,
    S_SHIFT,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t         opcode;
    logic [63:0] user_key;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic    active;
    status_t status;
  } out_item_t;

  localparam logic [31:0] TIMEOUT_RESET = 32'd300;

endpackage

// ===== sv/session_timeout_table.sv =====
// ---------------------------------------------------------------------------
// Session timeout table
// Bounded session list in one synchronous RAM, oldest entry at address 0,
// newest at address count-1. Lookups scan from the newest entry down; an end
// closes the gap by moving the newer entries down one address at a time.
// ---------------------------------------------------------------------------
//  channel | signals                    | beat
//  --------+----------------------------+-------------------------------
//  in      | in_valid/in_ready/in_data  | opcode, user_key, now
//  out     | out_valid/out_ready/out_data | active, status
//  cfg     | cfg_valid/cfg_ready/cfg_data | timeout (always ready)
//
//  Create, and any item on an empty table, goes from accept straight to the
//  result state. Query and refresh scan from the newest entry down to the
//  match; a miss scans the whole table. End then compacts the entries newer
//  than the match, one RAM read and one write per cycle.
//  One item at a time. Reset empties the table at once (fill count) and sets
//  timeout to 300. A result waiting on out_ready does not hold back the next
//  input beat.
// ---------------------------------------------------------------------------
module session_timeout_table #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  stt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stt_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] stamp;
  } entry_t;

  entry_t             mem [NUM_ENTRIES];
  entry_t             rd_data;

  stt_pkg::state_t    state;
  stt_pkg::state_t    state_next;
  stt_pkg::in_item_t  item;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_dec;
  logic [CW-1:0]      src;
  logic               rd_pending;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      hit_idx;
  logic [31:0]        hit_stamp;
  logic               res_active;
  stt_pkg::status_t   res_status;
  logic [31:0]        timeout;

  logic               accept;
  logic               full;
  logic               hit;
  logic               scan_end;
  logic               more;
  logic               load_out;
  logic [31:0]        age;
  logic               mem_re;
  logic [AW-1:0]      mem_ra;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  entry_t             mem_wd;

  assign accept    = in_valid && in_ready;
  assign full      = (count == CW'(NUM_ENTRIES));
  assign count_dec = count - CW'(1);
  assign hit       = rd_pending && (rd_data.key == item.user_key);
  assign scan_end  = rd_pending && (rd_idx == '0);
  assign more      = (src < count);
  assign age       = item.now - hit_stamp;
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      stt_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == stt_pkg::OP_CREATE || count == '0) begin
            state_next = stt_pkg::S_FIN;
          end else begin
            state_next = stt_pkg::S_SEARCH;
          end
        end
      end
      stt_pkg::S_SEARCH: begin
        if (hit) begin
          state_next = stt_pkg::S_ACT;
        end else if (scan_end) begin
          state_next = stt_pkg::S_FIN;
        end
      end
      stt_pkg::S_ACT: begin
        if (item.opcode == stt_pkg::OP_END) begin
          state_next = stt_pkg::S_SHIFT;
        end else begin
          state_next = stt_pkg::S_FIN;
        end
      end
      stt_pkg::S_SHIFT: begin
        if (!more && !rd_pending) begin
          state_next = stt_pkg::S_FIN;
        end
      end
      stt_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = stt_pkg::S_IDLE;
        end
      end
      default: state_next = stt_pkg::S_IDLE;
    endcase
  end

  // Handshake and RAM port control
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    mem_re   = 1'b0;
    mem_ra   = '0;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    case (state)
      stt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        // append a created session above the newest
        mem_we   = in_valid && (in_data.opcode == stt_pkg::OP_CREATE) && !full;
        mem_wa   = count[AW-1:0];
        mem_wd   = '{key: in_data.user_key, stamp: in_data.now};
      end
      stt_pkg::S_SEARCH: begin
        mem_re = !hit && !scan_end;
        mem_ra = rd_pending ? (rd_idx - AW'(1)) : count_dec[AW-1:0];
      end
      stt_pkg::S_ACT: begin
        mem_we = (item.opcode == stt_pkg::OP_REFRESH);
        mem_wa = hit_idx;
        mem_wd = '{key: item.user_key, stamp: item.now};
      end
      stt_pkg::S_SHIFT: begin
        // read the next newer entry, write the previous one a slot lower
        mem_re = more;
        mem_ra = src[AW-1:0];
        mem_we = rd_pending;
        mem_wa = rd_idx;
        mem_wd = rd_data;
      end
      stt_pkg::S_FIN: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= stt_pkg::S_IDLE;
      count      <= '0;
      rd_pending <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        stt_pkg::S_IDLE: begin
          if (accept) begin
            rd_pending <= 1'b0;
            if (in_data.opcode == stt_pkg::OP_CREATE && !full) begin
              count <= count + CW'(1);
            end
          end
        end
        stt_pkg::S_SEARCH: begin
          if (!hit && !scan_end) begin
            rd_pending <= 1'b1;
            rd_idx     <= mem_ra;
          end
        end
        stt_pkg::S_ACT: begin
          rd_pending <= 1'b0;
        end
        stt_pkg::S_SHIFT: begin
          rd_pending <= more;
          if (more) begin
            rd_idx <= src[AW-1:0] - AW'(1);
          end
          if (!more && !rd_pending) begin
            count <= count_dec;
          end
        end
        default: begin
          rd_pending <= rd_pending;
        end
      endcase
    end
  end

  // Item payload, match and result registers
  always_ff @(posedge clk) begin
    case (state)
      stt_pkg::S_IDLE: begin
        if (accept) begin
          item       <= in_data;
          res_active <= 1'b0;
          if (in_data.opcode == stt_pkg::OP_CREATE) begin
            res_status <= full ? stt_pkg::STAT_FULL : stt_pkg::STAT_OK;
          end else begin
            res_status <= (count == '0) ? stt_pkg::STAT_MISSING : stt_pkg::STAT_OK;
          end
        end
      end
      stt_pkg::S_SEARCH: begin
        if (hit) begin
          hit_idx   <= rd_idx;
          hit_stamp <= rd_data.stamp;
        end else if (scan_end) begin
          res_status <= stt_pkg::STAT_MISSING;
        end
      end
      stt_pkg::S_ACT: begin
        if (item.opcode == stt_pkg::OP_QUERY) begin
          res_active <= (age < timeout);
        end
        src <= CW'(hit_idx) + CW'(1);
      end
      stt_pkg::S_SHIFT: begin
        if (more) begin
          src <= src + CW'(1);
        end
      end
      default: begin
        src <= src;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= '{active: res_active, status: res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= stt_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

endmodule

// ===== sv/session_timeout_table_chk.sv =====
// ---------------------------------------------------------------------------
// Session timeout table: port checker
// Watches the ports of the session table over time; bound to the top level.
// ---------------------------------------------------------------------------
`include "session_timeout_table_defines.svh"

module session_timeout_table_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input stt_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // a stalled result beat must hold
  `STT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // the timeout register takes a write on every cycle
  `STT_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

  // one item in work at a time: input closes right after an accepted beat
  `STT_ASSERT_NEXT(a_in_close, in_valid && in_ready, !in_ready, "second beat taken while item in work")

  // a fresh result only appears after an item was in work
  `STT_ASSERT_NOW(a_out_src, $rose(out_valid), !$past(in_ready), "result raised while table idle")

endmodule

bind session_timeout_table session_timeout_table_chk u_chk (.*);

// ===== tb/session_timeout_table_tb.sv =====
// ---------------------------------------------------------------------------
// Session timeout table: testbench
// Opens with a short table of directed beats (empty table, ageing limits,
// wrapping time, shadowed keys, a full table), then runs random session
// traffic under several timeout settings and idling patterns. Each result
// beat is held to its directed row or an in-bench session list, newest first.
// ---------------------------------------------------------------------------
module session_timeout_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 205;

  typedef struct {
    stt_pkg::in_item_t  item;
    bit                 known;
    stt_pkg::out_item_t want;
  } dir_row_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  stt_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  stt_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_data  = '0;

  // Session list as the block should hold it, cell 0 newest
  logic [63:0] sess_key  [DEPTH];
  logic [31:0] sess_time [DEPTH];
  bit          sess_vld  [DEPTH];
  logic [31:0] sess_timeout;

  stt_pkg::out_item_t expected_q[$];
  dir_row_t           dir_rows[$];
  bit                 row_known = 1'b0;
  stt_pkg::out_item_t row_want  = '0;
  stt_pkg::out_item_t guess;
  stt_pkg::out_item_t want;

  int          mismatches   = 0;
  int          cycles       = 0;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          hold_left    = 0;

  session_timeout_table #(
    .NUM_ENTRIES(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic stt_pkg::out_item_t predict_session(stt_pkg::in_item_t it);
    stt_pkg::out_item_t r;
    int                 hit;
    logic [31:0]        age;
    r.active = 1'b0;
    r.status = stt_pkg::STAT_OK;
    hit      = DEPTH;
    if (it.opcode == stt_pkg::OP_CREATE) begin
      if (sess_vld[DEPTH-1]) begin
        r.status = stt_pkg::STAT_FULL;
      end else begin
        for (int i = DEPTH - 1; i > 0; i--) begin
          sess_key[i]  = sess_key[i-1];
          sess_time[i] = sess_time[i-1];
          sess_vld[i]  = sess_vld[i-1];
        end
        sess_key[0]  = it.user_key;
        sess_time[0] = it.now;
        sess_vld[0]  = 1'b1;
      end
    end else begin
      for (int i = DEPTH - 1; i >= 0; i--) begin
        if (sess_vld[i] && sess_key[i] == it.user_key) hit = i;
      end
      if (hit == DEPTH) begin
        r.status = stt_pkg::STAT_MISSING;
      end else if (it.opcode == stt_pkg::OP_QUERY) begin
        age      = it.now - sess_time[hit];
        r.active = (age < sess_timeout);
      end else if (it.opcode == stt_pkg::OP_REFRESH) begin
        sess_time[hit] = it.now;
      end else begin
        // close the gap left by the ended session
        for (int i = hit; i < DEPTH - 1; i++) begin
          sess_key[i]  = sess_key[i+1];
          sess_time[i] = sess_time[i+1];
          sess_vld[i]  = sess_vld[i+1];
        end
        sess_vld[DEPTH-1] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic void add_row(stt_pkg::op_t op, logic [63:0] k, logic [31:0] t,
                                  bit known, logic act, stt_pkg::status_t st);
    dir_row_t row;
    row.item.opcode   = op;
    row.item.user_key = k;
    row.item.now      = t;
    row.known         = known;
    row.want.active   = act;
    row.want.status   = st;
    dir_rows.push_back(row);
  endfunction

  // Monitor: predict on every accepted input beat, check every result beat
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sess_timeout = cfg_data;
      if (in_valid && in_ready) begin
        guess = predict_session(in_data);
        expected_q.push_back(row_known ? row_want : guess);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, actual active %0b status %0d",
                   $time, out_data.active, out_data.status);
        end else begin
          want = expected_q.pop_front();
          if (out_data.active !== want.active) begin
            mismatches++;
            $display("%0t: active mismatch, expected %0b, actual %0b",
                     $time, want.active, out_data.active);
          end
          if (out_data.status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data.status);
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left runs down
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(stt_pkg::in_item_t it, bit known, stt_pkg::out_item_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    row_known <= known;
    row_want  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_timeout(logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [63:0]       key_pool [8];
    logic [31:0]       phase_timeout [PHASES];
    int                create_pct [PHASES];
    logic [31:0]       clock_now;
    stt_pkg::in_item_t it;
    int                pick;

    for (int i = 0; i < DEPTH; i++) sess_vld[i] = 1'b0;
    sess_timeout = stt_pkg::TIMEOUT_RESET;

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h5555_5555_5555_5555;
    key_pool[3] = 64'hAAAA_AAAA_AAAA_AAAA;
    for (int i = 4; i < 8; i++) key_pool[i] = {$urandom, $urandom};

    phase_timeout = '{stt_pkg::TIMEOUT_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1,
                      32'($urandom_range(2, 600)), $urandom, 32'h8000_0000, 32'd150};
    create_pct    = '{35, 55, 25, 60, 30, 20, 50, 40};

    // Empty table, ageing edges, wrapping time, duplicates, full table
    add_row(stt_pkg::OP_QUERY,   '0, '0, 1'b1, 1'b0, stt_pkg::STAT_MISSING);
    add_row(stt_pkg::OP_REFRESH, '1, '1, 1'b1, 1'b0, stt_pkg::STAT_MISSING);
    add_row(stt_pkg::OP_END,     64'h5, '0, 1'b1, 1'b0, stt_pkg::STAT_MISSING);
    add_row(stt_pkg::OP_CREATE,  '0, '0, 1'b1, 1'b0, stt_pkg::STAT_OK);
    add_row(stt_pkg::OP_QUERY,   '0, 32'd299, 1'b1, 1'b1, stt_pkg::STAT_OK);
    add_row(stt_pkg::OP_QUERY,   '0, 32'd300, 1'b1, 1'b0, stt_pkg::STAT_OK);
    add_row(stt_pkg::OP_QUERY,   '0, 32'hFFFF_FFFF, 1'b1, 1'b0, stt_pkg::STAT_OK);
    add_row(stt_pkg::OP_CREATE,  '1, 32'hFFFF_FFFF, 1'b1, 1'b0, stt_pkg::STAT_OK);
    add_row(stt_pkg::OP_QUERY,   '1, 32'h0000_012A, 1'b1, 1'b1, stt_pkg::STAT_OK);
    for (int i = 0; i < 14; i++) begin
      add_row(stt_pkg::OP_CREATE, i[0] ? '1 : '0, 32'd1000 + i, 1'b1, 1'b0,
              stt_pkg::STAT_OK);
    end
    add_row(stt_pkg::OP_CREATE,  64'h1234_5678_9ABC_DEF0, 32'd2000, 1'b1, 1'b0,
            stt_pkg::STAT_FULL);
    add_row(stt_pkg::OP_REFRESH, '0, 32'd3000, 1'b1, 1'b0, stt_pkg::STAT_OK);
    add_row(stt_pkg::OP_END,     '1, 32'd3000, 1'b1, 1'b0, stt_pkg::STAT_OK);
    add_row(stt_pkg::OP_QUERY,   '0, 32'd3100, 1'b0, 1'b0, stt_pkg::STAT_OK);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
    drain_results();

    clock_now = 32'd5000;
    for (int p = 0; p < PHASES; p++) begin
      set_timeout(phase_timeout[p]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
      endcase
      // hold off the receiver so the block backs up onto its input
      if (p == 0) hold_left = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < create_pct[p]) it.opcode = stt_pkg::OP_CREATE;
        else if (pick < create_pct[p] + (100 - create_pct[p]) / 2) it.opcode = stt_pkg::OP_QUERY;
        else it.opcode = $urandom_range(0, 1) ? stt_pkg::OP_REFRESH : stt_pkg::OP_END;
        if ($urandom_range(0, 6) == 0) it.user_key = {$urandom, $urandom};
        else it.user_key = key_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 19))
          0:       clock_now = $urandom;
          1:       clock_now = clock_now - $urandom_range(1, 600);
          default: clock_now = clock_now + $urandom_range(0, 150);
        endcase
        it.now = clock_now;
        send_item(it, 1'b0, '0);
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/stt_pkg.sv
sv/session_timeout_table.sv
sv/session_timeout_table_chk.sv
tb/session_timeout_table_tb.sv
